### rtl/mrr_pkg.sv
// ----------------------------------------------------------------------------
// mrr_pkg: shared types and constants of the mailbox receiver
// Item layouts, status and action codes, register indexes, bank sizing and
// the lowest-set-bit search used by the slot scan.
// ----------------------------------------------------------------------------
package mrr_pkg;

  // Bank sizing
  localparam int NUM_SLOTS = 64;
  localparam int MSG_WIDTH = 64;

  // Fixed field widths of the items and registers
  localparam int SLOT_W    = 6;
  localparam int OUT_MSG_W = 64;
  localparam int ACT_W     = 7;
  localparam int CFG_W     = 7;

  // Derived widths
  localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int CNT_W = $clog2(NUM_SLOTS + 1);
  localparam int CMP_W = (ACT_W > CNT_W) ? ACT_W : CNT_W;

  typedef enum logic {
    ACT_DEPOSIT = 1'b0,
    ACT_RECEIVE = 1'b1
  } action_t;

  typedef enum logic [1:0] {
    ST_DEP_OK   = 2'd0,
    ST_DEP_FULL = 2'd1,
    ST_RECEIVED = 2'd2,
    ST_NO_MSG   = 2'd3
  } status_t;

  typedef enum logic {
    REG_ACTIVE_SLOTS = 1'b0,
    REG_SCAN_MODE    = 1'b1
  } reg_index_t;

  typedef enum logic [1:0] {
    FSM_IDLE,
    FSM_EXEC,
    FSM_READ
  } fsm_t;

  typedef struct packed {
    action_t               action;
    logic [SLOT_W-1:0]     slot;
    logic [OUT_MSG_W-1:0]  message;
  } in_item_t;

  typedef struct packed {
    status_t               status;
    logic [OUT_MSG_W-1:0]  received_message;
    logic [SLOT_W-1:0]     served_slot;
  } out_item_t;

  // Lowest set bit: {found, index}
  function automatic logic [IDX_W:0] find_first(input logic [NUM_SLOTS-1:0] v);
    logic [IDX_W:0] res;
    res = '0;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (v[i]) begin
        res = {1'b1, IDX_W'(i)};
      end
    end
    return res;
  endfunction

endpackage

### rtl/mailbox_round_robin_receiver.sv
// ----------------------------------------------------------------------------
// mailbox_round_robin_receiver: bank of one-message mailboxes
// Deposits fill a slot; receives take the next full slot in fixed or
// round-robin order and hand back its message.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : valid/ready channel of items. A deposit (action 0) stores
//           in_item.message into in_item.slot unless that slot is full. A
//           receive (action 1) serves the next full active slot.
//   out_* : valid/ready channel, one result item per input item, in order.
//   cfg_* : write-only port; cfg_we writes cfg_wdata to register cfg_index
//           (0 active slot count, 1 scan mode). Write only while idle.
// Timing: an item is taken in IDLE and worked in EXEC. Deposits and
//   receives that find no message load their result from EXEC; a served
//   receive adds a READ state for the message RAM read, whose result is
//   loaded from READ. One item is in flight at a time, so a new item is
//   taken only once the previous one has left EXEC or READ for IDLE.
// Reset: every slot empty, pointer at slot 0, 64 active slots, round robin.
//   Full bits are flip-flops cleared at once; the message RAM is not cleared.
// Stall: a finished result waits in the output register; the next item is
//   still taken, and its work holds until that register is free.
// ----------------------------------------------------------------------------
module mailbox_round_robin_receiver (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  mrr_pkg::in_item_t         in_item,
  output logic                      out_valid,
  input  logic                      out_ready,
  output mrr_pkg::out_item_t        out_item,
  input  logic                      cfg_we,
  input  mrr_pkg::reg_index_t       cfg_index,
  input  logic [mrr_pkg::CFG_W-1:0] cfg_wdata
);

  // Control state
  mrr_pkg::fsm_t                       state_r, state_nxt;
  logic [mrr_pkg::NUM_SLOTS-1:0]       full_r, full_nxt;
  logic [mrr_pkg::IDX_W-1:0]           next_slot_r, next_slot_nxt;
  logic [mrr_pkg::ACT_W-1:0]           active_slots_r;
  logic                                scan_mode_r;
  logic                                out_valid_r, out_valid_nxt;

  // Payload registers
  mrr_pkg::in_item_t                   item_r;
  mrr_pkg::out_item_t                  out_item_r, out_item_nxt;
  logic [mrr_pkg::IDX_W-1:0]           pend_slot_r;

  // Control decodes
  logic out_free;
  logic exec_go;
  logic rd_done;

  // Scan datapath
  logic [mrr_pkg::CMP_W-1:0]     act_ext;
  logic [mrr_pkg::CNT_W-1:0]     n_act;
  logic [mrr_pkg::IDX_W-1:0]     start;
  logic [mrr_pkg::NUM_SLOTS-1:0] mask_all, mask_hi;
  logic [mrr_pkg::IDX_W:0]       enc_all, enc_hi;
  logic                          hit;
  logic [mrr_pkg::IDX_W-1:0]     hit_idx;
  logic [mrr_pkg::CNT_W-1:0]     ptr_sum;

  // Deposit datapath
  logic [mrr_pkg::IDX_W-1:0]     dep_idx;
  logic                          dep_ok;
  logic                          is_recv;

  // RAM ports
  logic                          ram_we, ram_re;
  logic [mrr_pkg::MSG_WIDTH-1:0] ram_rdata;

  assign out_free = !out_valid_r || out_ready;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      mrr_pkg::FSM_IDLE: begin
        if (in_valid) begin
          state_nxt = mrr_pkg::FSM_EXEC;
        end
      end
      mrr_pkg::FSM_EXEC: begin
        if (out_free) begin
          state_nxt = (is_recv && hit) ? mrr_pkg::FSM_READ : mrr_pkg::FSM_IDLE;
        end
      end
      mrr_pkg::FSM_READ: begin
        state_nxt = mrr_pkg::FSM_IDLE;
      end
      default: begin
        state_nxt = mrr_pkg::FSM_IDLE;
      end
    endcase
  end

  // State outputs
  always_comb begin
    in_ready = 1'b0;
    exec_go  = 1'b0;
    rd_done  = 1'b0;
    unique case (state_r)
      mrr_pkg::FSM_IDLE: in_ready = 1'b1;
      mrr_pkg::FSM_EXEC: exec_go  = out_free;
      mrr_pkg::FSM_READ: rd_done  = 1'b1;
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  // Effective active count: values above the bank size act as the bank size
  assign act_ext = mrr_pkg::CMP_W'(active_slots_r);
  assign n_act   = (act_ext > mrr_pkg::CMP_W'(mrr_pkg::NUM_SLOTS)) ?
                   mrr_pkg::CNT_W'(mrr_pkg::NUM_SLOTS) : mrr_pkg::CNT_W'(act_ext);

  // Round robin starts at the pointer; a stale pointer falls back to slot 0
  assign start = (scan_mode_r && (mrr_pkg::CNT_W'(next_slot_r) < n_act)) ?
                 next_slot_r : '0;

  // Split the active full slots at the start point; upper part wins
  always_comb begin
    for (int i = 0; i < mrr_pkg::NUM_SLOTS; i++) begin
      mask_all[i] = full_r[i] && (mrr_pkg::CNT_W'(i) < n_act);
      mask_hi[i]  = mask_all[i] && (mrr_pkg::IDX_W'(i) >= start);
    end
  end

  assign enc_all = mrr_pkg::find_first(mask_all);
  assign enc_hi  = mrr_pkg::find_first(mask_hi);
  assign hit     = enc_all[mrr_pkg::IDX_W];
  assign hit_idx = enc_hi[mrr_pkg::IDX_W] ? enc_hi[mrr_pkg::IDX_W-1:0] :
                                            enc_all[mrr_pkg::IDX_W-1:0];
  assign ptr_sum = mrr_pkg::CNT_W'(hit_idx) + mrr_pkg::CNT_W'(1);

  // Deposit check: slot inside the bank and empty
  assign is_recv = (item_r.action == mrr_pkg::ACT_RECEIVE);
  assign dep_idx = mrr_pkg::IDX_W'(item_r.slot);
  assign dep_ok  = (mrr_pkg::CNT_W'(item_r.slot) < mrr_pkg::CNT_W'(mrr_pkg::NUM_SLOTS))
                   && !full_r[dep_idx];

  assign ram_we = exec_go && !is_recv && dep_ok;
  assign ram_re = exec_go && is_recv && hit;

  mrr_ram #(
    .WIDTH (mrr_pkg::MSG_WIDTH),
    .DEPTH (mrr_pkg::NUM_SLOTS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (dep_idx),
    .wdata (item_r.message[mrr_pkg::MSG_WIDTH-1:0]),
    .re    (ram_re),
    .raddr (hit_idx),
    .rdata (ram_rdata)
  );

  // Full bits and pointer: set on an accepted deposit, clear and, in round-robin
  // mode, advance on a served receive
  always_comb begin
    full_nxt      = full_r;
    next_slot_nxt = next_slot_r;
    if (ram_we) begin
      full_nxt[dep_idx] = 1'b1;
    end
    if (ram_re) begin
      full_nxt[hit_idx] = 1'b0;
      if (scan_mode_r) begin
        next_slot_nxt = (ptr_sum >= n_act) ? '0 : mrr_pkg::IDX_W'(ptr_sum);
      end
    end
  end

  // Output register: load direct results in EXEC, RAM data in READ
  always_comb begin
    out_item_nxt  = out_item_r;
    out_valid_nxt = out_valid_r && !out_ready;
    if (rd_done) begin
      out_item_nxt.status           = mrr_pkg::ST_RECEIVED;
      out_item_nxt.received_message = mrr_pkg::OUT_MSG_W'(ram_rdata);
      out_item_nxt.served_slot      = mrr_pkg::SLOT_W'(pend_slot_r);
      out_valid_nxt                 = 1'b1;
    end else if (exec_go && !ram_re) begin
      out_item_nxt.received_message = '0;
      out_item_nxt.served_slot      = '0;
      if (is_recv) begin
        out_item_nxt.status = mrr_pkg::ST_NO_MSG;
      end else if (dep_ok) begin
        out_item_nxt.status = mrr_pkg::ST_DEP_OK;
      end else begin
        out_item_nxt.status = mrr_pkg::ST_DEP_FULL;
      end
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= mrr_pkg::FSM_IDLE;
      full_r         <= '0;
      next_slot_r    <= '0;
      active_slots_r <= mrr_pkg::ACT_W'(64);
      scan_mode_r    <= 1'b1;
      out_valid_r    <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      full_r      <= full_nxt;
      next_slot_r <= next_slot_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          mrr_pkg::REG_ACTIVE_SLOTS: active_slots_r <= mrr_pkg::ACT_W'(cfg_wdata);
          mrr_pkg::REG_SCAN_MODE:    scan_mode_r    <= cfg_wdata[0];
          default: begin
            scan_mode_r <= scan_mode_r;
          end
        endcase
      end
    end
  end

  // Payload: hold the accepted item, the served slot and the result
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
    if (ram_re) begin
      pend_slot_r <= hit_idx;
    end
    out_item_r <= out_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

### rtl/mrr_ram.sv
// ----------------------------------------------------------------------------
// mrr_ram: generic single-clock RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module mrr_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic                                    re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
